@@ rtl/core/bbg_pkg.sv @@
// shared widths, register and face codes, and types for the box boundary ghost generator
package bbg_pkg;

	localparam int INDEX_BITS  = 20;
	localparam int COORD_W     = 32;
	localparam int LEN_W       = 31;
	localparam int FACTOR_W    = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int FACE_W      = 3;
	localparam int NUM_AXES    = 3;
	localparam int NUM_FACES   = 6;
	localparam int FRAC_SHIFT  = 12;
	localparam int PROD_W      = LEN_W + FACTOR_W;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_BOX_LOW_X  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BOX_LOW_Y  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BOX_LOW_Z  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BOX_HIGH_X = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BOX_HIGH_Y = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_BOX_HIGH_Z = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_REACH      = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_GAP    = 3'd7;

	// face codes, low faces first
	localparam logic [FACE_W-1:0] FACE_LOW_X  = 3'd0;
	localparam logic [FACE_W-1:0] FACE_LOW_Y  = 3'd1;
	localparam logic [FACE_W-1:0] FACE_LOW_Z  = 3'd2;
	localparam logic [FACE_W-1:0] FACE_HIGH_X = 3'd3;
	localparam logic [FACE_W-1:0] FACE_HIGH_Y = 3'd4;
	localparam logic [FACE_W-1:0] FACE_HIGH_Z = 3'd5;

	localparam logic [COORD_W-1:0]  BOX_LOW_RESET  = 32'h0000_0000;
	localparam logic [COORD_W-1:0]  BOX_HIGH_RESET = 32'h0001_0000;
	localparam logic [FACTOR_W-1:0] REACH_RESET    = 16'd8192;
	localparam logic [FACTOR_W-1:0] MIN_GAP_RESET  = 16'd410;

	typedef struct packed {
		logic [NUM_AXES-1:0][COORD_W-1:0] box_low;
		logic [NUM_AXES-1:0][COORD_W-1:0] box_high;
		logic [FACTOR_W-1:0]              reach;
		logic [FACTOR_W-1:0]              min_gap;
	} cfg_t;

	// one particle with all of its candidate ghosts
	typedef struct packed {
		logic [NUM_AXES-1:0][COORD_W-1:0]  pos;
		logic [NUM_FACES-1:0][COORD_W-1:0] mirror;
		logic [LEN_W-1:0]                  len;
		logic [INDEX_BITS-1:0]             index;
		logic [NUM_FACES-1:0]              mask;
	} ghost_set_t;

endpackage

@@ rtl/core/bbg_cfg.sv @@
// configuration register file for the box corners and the reach and gap factors
module bbg_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bbg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bbg_pkg::COORD_W-1:0]     cfg_data,
	output bbg_pkg::cfg_t                   cfg
);

	bbg_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_low  <= {bbg_pkg::NUM_AXES{bbg_pkg::BOX_LOW_RESET}};
			cfg_q.box_high <= {bbg_pkg::NUM_AXES{bbg_pkg::BOX_HIGH_RESET}};
			cfg_q.reach    <= bbg_pkg::REACH_RESET;
			cfg_q.min_gap  <= bbg_pkg::MIN_GAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bbg_pkg::REG_BOX_LOW_X:  cfg_q.box_low[0]  <= cfg_data;
				bbg_pkg::REG_BOX_LOW_Y:  cfg_q.box_low[1]  <= cfg_data;
				bbg_pkg::REG_BOX_LOW_Z:  cfg_q.box_low[2]  <= cfg_data;
				bbg_pkg::REG_BOX_HIGH_X: cfg_q.box_high[0] <= cfg_data;
				bbg_pkg::REG_BOX_HIGH_Y: cfg_q.box_high[1] <= cfg_data;
				bbg_pkg::REG_BOX_HIGH_Z: cfg_q.box_high[2] <= cfg_data;
				bbg_pkg::REG_REACH:      cfg_q.reach   <= cfg_data[bbg_pkg::FACTOR_W-1:0];
				bbg_pkg::REG_MIN_GAP:    cfg_q.min_gap <= cfg_data[bbg_pkg::FACTOR_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/bbg_pipe.sv @@
// three stage datapath: inside test and thresholds, face qualification, mirrored coordinates
module bbg_pipe (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bbg_pkg::cfg_t                  cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bbg_pkg::COORD_W-1:0]    pos_x,
	input  logic [bbg_pkg::COORD_W-1:0]    pos_y,
	input  logic [bbg_pkg::COORD_W-1:0]    pos_z,
	input  logic [bbg_pkg::LEN_W-1:0]      smooth_len,
	input  logic [bbg_pkg::INDEX_BITS-1:0] particle_index,
	output logic                           set_valid,
	input  logic                           set_ready,
	output bbg_pkg::ghost_set_t            set
);

	localparam int MIRROR_W = bbg_pkg::PROD_W + 3;
	localparam int FLOOR_W  = MIRROR_W - bbg_pkg::FRAC_SHIFT;
	localparam int PAD_W    = MIRROR_W - bbg_pkg::COORD_W - bbg_pkg::FRAC_SHIFT;
	localparam int DQ_PAD_W = bbg_pkg::PROD_W - bbg_pkg::COORD_W - bbg_pkg::FRAC_SHIFT;

	// floor result to signed 32 bits with saturation
	function automatic logic [bbg_pkg::COORD_W-1:0] sat_coord(input logic [FLOOR_W-1:0] v);
		logic [FLOOR_W-bbg_pkg::COORD_W:0] top;
		top = v[FLOOR_W-1:bbg_pkg::COORD_W-1];
		if ((&top) || !(|top))
			return v[bbg_pkg::COORD_W-1:0];
		else if (v[FLOOR_W-1])
			return {1'b1, {(bbg_pkg::COORD_W-1){1'b0}}};
		else
			return {1'b0, {(bbg_pkg::COORD_W-1){1'b1}}};
	endfunction

	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	assign ready_s3 = !valid_s3 || set_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// stage 1
	logic [bbg_pkg::NUM_AXES-1:0][bbg_pkg::COORD_W-1:0]  pos_in;
	logic [bbg_pkg::NUM_FACES-1:0][bbg_pkg::COORD_W-1:0] dist_c;
	logic                                                inside_c;
	logic [bbg_pkg::PROD_W-1:0]                          gap_c, reach_c;

	assign pos_in = {pos_z, pos_y, pos_x};

	always_comb begin
		inside_c = 1'b1;
		for (int a = 0; a < bbg_pkg::NUM_AXES; a++) begin
			if ($signed(pos_in[a]) < $signed(cfg.box_low[a]) ||
			    $signed(pos_in[a]) > $signed(cfg.box_high[a]))
				inside_c = 1'b0;
			// nonnegative and below 2^32 whenever the particle is inside
			dist_c[a]                    = pos_in[a] - cfg.box_low[a];
			dist_c[a + bbg_pkg::NUM_AXES] = cfg.box_high[a] - pos_in[a];
		end
	end

	assign gap_c   = {{bbg_pkg::LEN_W{1'b0}}, cfg.min_gap} *
	                 {{bbg_pkg::FACTOR_W{1'b0}}, smooth_len};
	assign reach_c = {{bbg_pkg::LEN_W{1'b0}}, cfg.reach} *
	                 {{bbg_pkg::FACTOR_W{1'b0}}, smooth_len};

	logic [bbg_pkg::NUM_AXES-1:0][bbg_pkg::COORD_W-1:0]  pos_s1;
	logic [bbg_pkg::NUM_FACES-1:0][bbg_pkg::COORD_W-1:0] dist_s1;
	logic                                                inside_s1;
	logic [bbg_pkg::PROD_W-1:0]                          gap_s1, reach_s1;
	logic [bbg_pkg::LEN_W-1:0]                           len_s1;
	logic [bbg_pkg::INDEX_BITS-1:0]                      index_s1;

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			pos_s1    <= pos_in;
			dist_s1   <= dist_c;
			inside_s1 <= inside_c;
			gap_s1    <= gap_c;
			reach_s1  <= reach_c;
			len_s1    <= smooth_len;
			index_s1  <= particle_index;
		end
	end

	// stage 2
	logic [bbg_pkg::NUM_FACES-1:0][bbg_pkg::PROD_W-1:0] dq_c, dqf_c;
	logic [bbg_pkg::NUM_FACES-1:0]                      mask_c;

	always_comb begin
		for (int f = 0; f < bbg_pkg::NUM_FACES; f++) begin
			dq_c[f]   = {{DQ_PAD_W{1'b0}}, dist_s1[f], {bbg_pkg::FRAC_SHIFT{1'b0}}};
			dqf_c[f]  = (dq_c[f] < gap_s1) ? gap_s1 : dq_c[f];
			mask_c[f] = inside_s1 && (dqf_c[f] < reach_s1);
		end
	end

	logic [bbg_pkg::NUM_AXES-1:0][bbg_pkg::COORD_W-1:0] pos_s2;
	logic [bbg_pkg::NUM_FACES-1:0][bbg_pkg::PROD_W-1:0] dqf_s2;
	logic [bbg_pkg::NUM_FACES-1:0]                      mask_s2;
	logic [bbg_pkg::LEN_W-1:0]                          len_s2;
	logic [bbg_pkg::INDEX_BITS-1:0]                     index_s2;

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			pos_s2   <= pos_s1;
			dqf_s2   <= dqf_c;
			mask_s2  <= mask_c;
			len_s2   <= len_s1;
			index_s2 <= index_s1;
		end
	end

	// stage 3
	logic [bbg_pkg::NUM_FACES-1:0][MIRROR_W-1:0]         p28_c, step_c, sum_c;
	logic [bbg_pkg::NUM_FACES-1:0][bbg_pkg::COORD_W-1:0] mirror_c;

	always_comb begin
		for (int f = 0; f < bbg_pkg::NUM_FACES; f++) begin
			p28_c[f] = {{PAD_W{pos_s2[f % bbg_pkg::NUM_AXES][bbg_pkg::COORD_W-1]}},
			            pos_s2[f % bbg_pkg::NUM_AXES], {bbg_pkg::FRAC_SHIFT{1'b0}}};
			step_c[f] = {2'b00, dqf_s2[f], 1'b0};
			// high faces push outward in +, low faces in -
			sum_c[f]  = (f >= bbg_pkg::NUM_AXES) ? p28_c[f] + step_c[f] : p28_c[f] - step_c[f];
			mirror_c[f] = sat_coord(sum_c[f][MIRROR_W-1:bbg_pkg::FRAC_SHIFT]);
		end
	end

	bbg_pkg::ghost_set_t set_s3;

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			set_s3.pos    <= pos_s2;
			set_s3.mirror <= mirror_c;
			set_s3.len    <= len_s2;
			set_s3.index  <= index_s2;
			set_s3.mask   <= mask_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= in_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
			if (ready_s3)
				valid_s3 <= valid_s2;
		end
	end

	assign set_valid = valid_s3;
	assign set       = set_s3;

endmodule

@@ rtl/core/bbg_emit.sv @@
// output register that drains the qualified ghosts of one particle, one beat per face
module bbg_emit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           set_valid,
	output logic                           set_take,
	input  bbg_pkg::ghost_set_t            set,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bbg_pkg::COORD_W-1:0]    ghost_x,
	output logic [bbg_pkg::COORD_W-1:0]    ghost_y,
	output logic [bbg_pkg::COORD_W-1:0]    ghost_z,
	output logic [bbg_pkg::LEN_W-1:0]      ghost_len,
	output logic [bbg_pkg::INDEX_BITS-1:0] source_index,
	output logic [bbg_pkg::FACE_W-1:0]     face_id,
	output logic                           last_ghost
);

	bbg_pkg::ghost_set_t           item_q;
	logic [bbg_pkg::NUM_FACES-1:0] mask_q;
	logic [bbg_pkg::NUM_FACES-1:0] sel_oh;
	logic                          busy, beat, last_c;
	logic [bbg_pkg::NUM_AXES-1:0][bbg_pkg::COORD_W-1:0] coord_c;
	logic [bbg_pkg::FACE_W-1:0]    face_c;

	assign busy     = |mask_q;
	assign sel_oh   = mask_q & (~mask_q + 1'b1);
	assign last_c   = (mask_q & (mask_q - 1'b1)) == '0;
	assign beat     = busy && out_ready;
	// a new set loads when nothing is left or the final ghost leaves now
	assign set_take = !busy || (out_ready && last_c);

	always_comb begin
		coord_c = item_q.pos;
		face_c  = bbg_pkg::FACE_LOW_X;
		for (int f = 0; f < bbg_pkg::NUM_FACES; f++) begin
			if (sel_oh[f]) begin
				coord_c[f % bbg_pkg::NUM_AXES] = item_q.mirror[f];
				face_c = bbg_pkg::FACE_W'(f);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (set_take) begin
			mask_q <= set_valid ? set.mask : '0;
		end else if (beat) begin
			mask_q <= mask_q & ~sel_oh;
		end
	end

	always_ff @(posedge clk) begin
		if (set_take && set_valid)
			item_q <= set;
	end

	assign out_valid    = busy;
	assign ghost_x      = coord_c[0];
	assign ghost_y      = coord_c[1];
	assign ghost_z      = coord_c[2];
	assign ghost_len    = item_q.len;
	assign source_index = item_q.index;
	assign face_id      = face_c;
	assign last_ghost   = last_c;

	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		beat && !last_c |=> out_valid)
		else $error("ghost run ended before its last beat");

	a_face_order: assert property (@(posedge clk) disable iff (!arst_n)
		beat && !last_c |=> face_id > $past(face_id))
		else $error("ghost faces out of order");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		set_take && set_valid && (set.mask != '0) |=> out_valid)
		else $error("loaded ghost set not presented");

	a_drain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		beat && last_c && !set_valid |=> !out_valid)
		else $error("ghost appeared after run drained with no new set");

endmodule

@@ rtl/core/box_boundary_ghosts.sv @@
// top level of the box boundary mirror ghost generator
// Usage:
//   input channel (in_valid/in_ready) takes one particle per beat: pos_x,
//   pos_y, pos_z, smooth_len and particle_index. output channel
//   (out_valid/out_ready) gives one ghost per beat, faces in order low x,
//   low y, low z, high x, high y, high z, last_ghost set on the final one.
//   a particle outside the box, or one with no face in reach, gives no beat.
//   configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
//   always ready; write it only while no particle is in flight.
// Pipeline: three pipeline stages plus the output register; the first ghost
//   of a particle is registered in each stage, then in the output register.
// Throughput: one particle per cycle while each makes at most one ghost and
//   out_ready stays high; a particle with more ghosts holds the output
//   register until its last ghost leaves, and the pipeline stalls behind it.
// Stall: when out_ready is low the current ghost holds, the stages fill up
//   behind it and in_ready drops once no stage has room; nothing is lost.
// Reset: arst_n clears all valid bits and loads the default box (0 to 1.0
//   on each axis), reach 2.0 and minimum gap about 0.1.
module box_boundary_ghosts (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bbg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bbg_pkg::COORD_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bbg_pkg::COORD_W-1:0]     pos_x,
	input  logic [bbg_pkg::COORD_W-1:0]     pos_y,
	input  logic [bbg_pkg::COORD_W-1:0]     pos_z,
	input  logic [bbg_pkg::LEN_W-1:0]       smooth_len,
	input  logic [bbg_pkg::INDEX_BITS-1:0]  particle_index,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bbg_pkg::COORD_W-1:0]     ghost_x,
	output logic [bbg_pkg::COORD_W-1:0]     ghost_y,
	output logic [bbg_pkg::COORD_W-1:0]     ghost_z,
	output logic [bbg_pkg::LEN_W-1:0]       ghost_len,
	output logic [bbg_pkg::INDEX_BITS-1:0]  source_index,
	output logic [bbg_pkg::FACE_W-1:0]      face_id,
	output logic                            last_ghost
);

	bbg_pkg::cfg_t       cfg;
	bbg_pkg::ghost_set_t set;
	logic                set_valid, set_take;

	bbg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bbg_pipe u_pipe (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.smooth_len     (smooth_len),
		.particle_index (particle_index),
		.set_valid      (set_valid),
		.set_ready      (set_take),
		.set            (set)
	);

	bbg_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.set_valid    (set_valid),
		.set_take     (set_take),
		.set          (set),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ghost_x      (ghost_x),
		.ghost_y      (ghost_y),
		.ghost_z      (ghost_z),
		.ghost_len    (ghost_len),
		.source_index (source_index),
		.face_id      (face_id),
		.last_ghost   (last_ghost)
	);

endmodule
